/* hw/rtl/svbm_pkg.sv */
// shared types, constants and helpers for the symmetric visibility bit matrix
package svbm_pkg;

  // matrix geometry
  localparam int CELL_LIMIT    = 256;
  localparam int WORD_W        = 32;
  localparam int BIT_W         = $clog2(WORD_W);
  localparam int WORDS_PER_ROW = (CELL_LIMIT + WORD_W - 1) / WORD_W;
  localparam int STORE_DEPTH   = CELL_LIMIT * WORDS_PER_ROW;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int WCNT_W        = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;

  // field widths
  localparam int CMD_W   = 3;
  localparam int CELL_W  = 8;
  localparam int COUNT_W = 9;
  localparam int STAT_W  = 2;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR        = 3'd0,
    CMD_ADD_CELL     = 3'd1,
    CMD_LOOKUP       = 3'd2,
    CMD_NEXT_TRACE   = 3'd3,
    CMD_REPORT_TRACE = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NO_TRACE = 2'd3
  } status_e;

  // one command beat
  typedef struct packed {
    logic [CMD_W-1:0] command;
    cell_t            cell_a;
    cell_t            cell_b;
    logic             visible_flag;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic                pair_visible;
    logic                trace_pending;
    cell_t               trace_row;
    cell_t               trace_col;
    count_t              cell_count;
    logic [STAT_W-1:0]   status;
  } res_t;

  // memory port request from the sequencer
  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  // word address of the bit for a (row, col) pair
  function automatic addr_t word_addr(count_t row, cell_t col);
    addr_t row_base;
    addr_t col_word;
    row_base = ADDR_W'(ADDR_W'(row) * ADDR_W'(WORDS_PER_ROW));
    col_word = ADDR_W'(col >> BIT_W);
    return ADDR_W'(row_base + col_word);
  endfunction

endpackage

/* hw/rtl/svbm_if.sv */
// command and result channel interfaces
interface svbm_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [svbm_pkg::CMD_W-1:0]    command;
  logic [svbm_pkg::CELL_W-1:0]   cell_a;
  logic [svbm_pkg::CELL_W-1:0]   cell_b;
  logic                          visible_flag;

  modport source (output valid, command, cell_a, cell_b, visible_flag, input ready);
  modport sink   (input valid, command, cell_a, cell_b, visible_flag, output ready);
endinterface

interface svbm_res_if;
  logic                          valid;
  logic                          ready;
  logic                          pair_visible;
  logic                          trace_pending;
  logic [svbm_pkg::CELL_W-1:0]   trace_row;
  logic [svbm_pkg::CELL_W-1:0]   trace_col;
  logic [svbm_pkg::COUNT_W-1:0]  cell_count;
  logic [svbm_pkg::STAT_W-1:0]   status;

  modport source (output valid, pair_visible, trace_pending, trace_row, trace_col,
                  cell_count, status, input ready);
  modport sink   (input valid, pair_visible, trace_pending, trace_row, trace_col,
                  cell_count, status, output ready);
endinterface

/* hw/rtl/svbm_ram.sv */
// bit matrix word store, one write port and one registered read port
module svbm_ram import svbm_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output word_t    rdata_o
);

  word_t mem_q [STORE_DEPTH];
  word_t rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/svbm_seq.sv */
// command sequencer: cell count, trace cursor and word read-modify-write
module svbm_seq import svbm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  output logic     cmd_ready_o,
  input  cmd_t     cmd_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output res_t     res_o,
  output mem_req_t mem_req_o,
  input  word_t    mem_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_MERGE,
    S_RESP
  } state_e;

  state_e            state_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [STAT_W-1:0] status_q;
  logic              vis_q;
  logic              flag_q;
  addr_t             addr_q;
  logic [BIT_W-1:0]  bit_q;
  logic [WCNT_W-1:0] wcnt_q;
  count_t            cells_q;
  count_t            row_q;
  cell_t             col_q;

  logic   a_ok, b_ok, row_live, on_diag;
  cell_t  hi, lo;
  count_t col_inc;
  word_t  bit_mask;

  // decode helpers
  always_comb begin
    a_ok     = COUNT_W'(cmd_i.cell_a) < cells_q;
    b_ok     = COUNT_W'(cmd_i.cell_b) < cells_q;
    hi       = (cmd_i.cell_a > cmd_i.cell_b) ? cmd_i.cell_a : cmd_i.cell_b;
    lo       = (cmd_i.cell_a > cmd_i.cell_b) ? cmd_i.cell_b : cmd_i.cell_a;
    row_live = row_q < cells_q;
    on_diag  = COUNT_W'(col_q) == row_q;
    col_inc  = COUNT_W'(col_q) + COUNT_W'(1);
    bit_mask = WORD_W'(1) << bit_q;
  end

  // sequencer and registered state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmd_q    <= CMD_CLEAR;
      status_q <= ST_OK;
      vis_q    <= 1'b0;
      flag_q   <= 1'b0;
      addr_q   <= '0;
      bit_q    <= '0;
      wcnt_q   <= '0;
      cells_q  <= '0;
      row_q    <= '0;
      col_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q    <= cmd_i.command;
            status_q <= ST_OK;
            vis_q    <= 1'b0;
            wcnt_q   <= '0;
            state_q  <= S_RESP;
            case (cmd_i.command)
              CMD_CLEAR: begin
                cells_q <= '0;
                row_q   <= '0;
                col_q   <= '0;
              end
              CMD_ADD_CELL: begin
                if (cells_q >= COUNT_W'(CELL_LIMIT)) begin
                  status_q <= ST_FULL;
                end else begin
                  addr_q  <= word_addr(cells_q, '0);
                  state_q <= S_CLEAR;
                end
              end
              CMD_LOOKUP: begin
                if (!a_ok || !b_ok) begin
                  status_q <= ST_RANGE;
                end else begin
                  addr_q  <= word_addr(COUNT_W'(hi), lo);
                  bit_q   <= lo[BIT_W-1:0];
                  state_q <= S_READ;
                end
              end
              CMD_NEXT_TRACE: begin
                // diagonal pair is marked visible before handing out the next one
                if (on_diag && row_live) begin
                  addr_q  <= word_addr(row_q, col_q);
                  bit_q   <= col_q[BIT_W-1:0];
                  flag_q  <= 1'b1;
                  state_q <= S_READ;
                end
              end
              CMD_REPORT_TRACE: begin
                if (row_live) begin
                  addr_q  <= word_addr(row_q, col_q);
                  bit_q   <= col_q[BIT_W-1:0];
                  flag_q  <= cmd_i.visible_flag;
                  state_q <= S_READ;
                end else begin
                  status_q <= ST_NO_TRACE;
                end
              end
              default: ;
            endcase
          end
        end
        S_CLEAR: begin
          wcnt_q <= WCNT_W'(wcnt_q + WCNT_W'(1));
          if (wcnt_q == WCNT_W'(WORDS_PER_ROW - 1)) begin
            cells_q <= COUNT_W'(cells_q + COUNT_W'(1));
            state_q <= S_RESP;
          end
        end
        S_READ: begin
          state_q <= S_MERGE;
        end
        S_MERGE: begin
          if (cmd_q == CMD_LOOKUP) begin
            vis_q <= mem_rdata_i[bit_q];
          end else if (col_inc > row_q) begin
            row_q <= COUNT_W'(row_q + COUNT_W'(1));
            col_q <= '0;
          end else begin
            col_q <= col_inc[CELL_W-1:0];
          end
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // memory port requests
  always_comb begin
    mem_req_o = '0;
    case (state_q)
      S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ADDR_W'(addr_q + ADDR_W'(wcnt_q));
        mem_req_o.wdata = '0;
      end
      S_READ: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = addr_q;
      end
      S_MERGE: begin
        mem_req_o.we    = cmd_q != CMD_LOOKUP;
        mem_req_o.waddr = addr_q;
        mem_req_o.wdata = flag_q ? (mem_rdata_i | bit_mask) : (mem_rdata_i & ~bit_mask);
      end
      default: ;
    endcase
  end

  // result beat
  always_comb begin
    res_o.pair_visible  = vis_q;
    res_o.trace_pending = (cmd_q == CMD_NEXT_TRACE) && row_live;
    res_o.trace_row     = res_o.trace_pending ? row_q[CELL_W-1:0] : '0;
    res_o.trace_col     = res_o.trace_pending ? col_q : '0;
    res_o.cell_count    = cells_q;
    res_o.status        = status_q;
  end

  assign cmd_ready_o = state_q == S_IDLE;
  assign res_valid_o = state_q == S_RESP;

endmodule

/* hw/rtl/symmetric_visibility_bit_matrix.sv */
// top level of the symmetric visibility bit matrix with its result register
// One command beat in gives one result beat out. Clear, a full-table add, an
// out-of-range lookup, a report with no pending pair, a next trace that needs no
// diagonal write and unknown codes go straight from accept to result; a lookup
// passes through the registered read of one 32-bit word, and a report and a next
// trace that marks a diagonal pair add the write back of that word; adding a cell
// clears its row one word at a time, WORDS_PER_ROW words (8 at 256 cells).
// The block takes one command at a time; a finished result sits in an output
// register so the next command can be accepted before the result beat is taken.
// The matrix store needs no clearing after reset, since every row is cleared
// when its cell is added.
module symmetric_visibility_bit_matrix import svbm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  svbm_cmd_if.sink   cmd_i,
  svbm_res_if.source res_o
);

  cmd_t     cmd;
  res_t     seq_res;
  res_t     res_q;
  logic     seq_res_valid;
  logic     slot_free;
  logic     out_valid_q;
  mem_req_t mem_req;
  word_t    mem_rdata;

  // pack the command beat
  always_comb begin
    cmd.command      = cmd_i.command;
    cmd.cell_a       = cmd_i.cell_a;
    cmd.cell_b       = cmd_i.cell_b;
    cmd.visible_flag = cmd_i.visible_flag;
  end

  assign slot_free = !out_valid_q || res_o.ready;

  svbm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .cmd_i       (cmd),
    .res_valid_o (seq_res_valid),
    .res_ready_i (slot_free),
    .res_o       (seq_res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  svbm_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_res_valid && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_res_valid && slot_free) begin
      res_q <= seq_res;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.pair_visible  = res_q.pair_visible;
  assign res_o.trace_pending = res_q.trace_pending;
  assign res_o.trace_row     = res_q.trace_row;
  assign res_o.trace_col     = res_q.trace_col;
  assign res_o.cell_count    = res_q.cell_count;
  assign res_o.status        = res_q.status;

`ifndef SYNTHESIS
  // busy after every accepted command beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready |=> !cmd_i.ready)
    else $error("command accepted while previous command still in flight");

  // a full-table answer only when the count is at its limit
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.status == ST_FULL) |-> res_q.cell_count == COUNT_W'(CELL_LIMIT))
    else $error("table full reported below the cell limit");

  // visible or pending results always carry an ok status
  a_flag_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.pair_visible || res_q.trace_pending) |-> res_q.status == ST_OK)
    else $error("result flag set with an error status");

  // a pending pair lies inside the live cells
  a_pending_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.trace_pending |->
      (COUNT_W'(res_q.trace_row) < res_q.cell_count) && (res_q.trace_col <= res_q.trace_row))
    else $error("pending trace pair outside the matrix");
`endif

endmodule
